[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/core/ostb_pkg.sv]
package ostb_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RANK_W     = SLOT_IDX_W;
    localparam int PTR_W      = $clog2(NUM_SLOTS + 1);

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 3;
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_SET_DUR = 3'd1,
        OP_START   = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_RESUME  = 3'd4,
        OP_CANCEL  = 3'd5,
        OP_QUERY   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACK,
        ST_TICK,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB
    } t_alu_mode;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] which_slot;
        logic [TIME_W-1:0] remaining_units;
        logic              is_active;
        logic              is_paused;
        logic              last;
    } t_result;

endpackage

[rtl/core/ostb_alu.sv]
// Shared 32-bit arithmetic unit.
// Add mode: res = a + b saturated at all ones, flag = res >= c.
// Subtract mode: res = c - a, flag = a >= c.
module ostb_alu (
    input  ostb_pkg::t_alu_mode          i_mode,
    input  logic [ostb_pkg::TIME_W-1:0]  i_a,
    input  logic [ostb_pkg::TIME_W-1:0]  i_b,
    input  logic [ostb_pkg::TIME_W-1:0]  i_c,
    output logic [ostb_pkg::TIME_W-1:0]  o_res,
    output logic                         o_flag
);

    logic [ostb_pkg::TIME_W:0]   sum;
    logic [ostb_pkg::TIME_W-1:0] sat;

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, i_b};
        sat = sum[ostb_pkg::TIME_W] ? '1 : sum[ostb_pkg::TIME_W-1:0];
        case (i_mode)
            ostb_pkg::ALU_ADD_SAT: begin
                o_res  = sat;
                o_flag = (sat >= i_c);
            end
            ostb_pkg::ALU_SUB: begin
                o_res  = i_c - i_a;
                o_flag = (i_a >= i_c);
            end
            default: begin
                o_res  = '0;
                o_flag = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/ostb_ctrl.sv]
`include "assert_macros.svh"

// Slot state and the sequencer that drives the shared arithmetic unit.
module ostb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ostb_pkg::OP_W-1:0]     i_op,
    input  logic [ostb_pkg::SLOT_W-1:0]   i_slot,
    input  logic [ostb_pkg::TIME_W-1:0]   i_duration,
    input  logic [ostb_pkg::DELTA_W-1:0]  i_delta,
    input  logic                          i_out_free,
    output logic                          o_emit_valid,
    output ostb_pkg::t_result             o_emit
);

    localparam int N = ostb_pkg::NUM_SLOTS;

    ostb_pkg::t_state r_state, n_state;

    ostb_pkg::t_op                    r_op;
    logic [ostb_pkg::SLOT_W-1:0]      r_slot;
    logic [ostb_pkg::TIME_W-1:0]      r_dur_in;
    logic [ostb_pkg::DELTA_W-1:0]     r_delta;
    logic [ostb_pkg::PTR_W-1:0]       r_ptr;

    logic [ostb_pkg::TIME_W-1:0]      r_duration [N];
    logic [ostb_pkg::TIME_W-1:0]      r_elapsed  [N];
    logic [ostb_pkg::RANK_W-1:0]      r_rank     [N];
    logic [N-1:0]                     r_active;
    logic [N-1:0]                     r_paused;

    logic [N-1:0]                      hit;
    logic                              any_hit;
    logic [ostb_pkg::SLOT_IDX_W-1:0]   hit_idx;
    logic [ostb_pkg::SLOT_IDX_W-1:0]   sidx;
    logic [ostb_pkg::SLOT_IDX_W-1:0]   rd_idx;
    logic                              in_bank;

    ostb_pkg::t_alu_mode               alu_mode;
    logic [ostb_pkg::TIME_W-1:0]       alu_b;
    logic [ostb_pkg::TIME_W-1:0]       alu_res;
    logic                              alu_flag;

    logic                              in_tick;
    logic                              in_exec;
    logic                              tick_paused;
    logic                              tick_expire;
    logic                              tick_write;
    logic                              tick_advance;
    logic                              drop_en;
    logic [ostb_pkg::RANK_W-1:0]       drop_rank;
    logic                              start_en;
    logic                              clear_elapsed;
    logic                              ack_active;
    logic                              emit_blocked;
    logic                              done_emit;

    assign sidx    = ostb_pkg::SLOT_IDX_W'(r_slot);
    assign in_bank = (int'(r_slot) < N);
    assign in_tick = (r_state == ostb_pkg::ST_TICK);
    assign in_exec = (r_state == ostb_pkg::ST_EXEC) && in_bank;

    // Ranks stay dense, so the slot at the pointer's rank is unique.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < N; i++) begin
            hit[i] = r_active[i] &&
                     (ostb_pkg::PTR_W'(r_rank[i]) == r_ptr);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = ostb_pkg::SLOT_IDX_W'(i);
            end
        end
        any_hit = |hit;
    end

    assign rd_idx   = in_tick ? hit_idx : sidx;
    assign alu_mode = in_tick ? ostb_pkg::ALU_ADD_SAT : ostb_pkg::ALU_SUB;
    assign alu_b    = in_tick ? ostb_pkg::TIME_W'(r_delta) : '0;

    ostb_alu u_alu (
        .i_mode (alu_mode),
        .i_a    (r_elapsed[rd_idx]),
        .i_b    (alu_b),
        .i_c    (r_duration[rd_idx]),
        .o_res  (alu_res),
        .o_flag (alu_flag)
    );

    // An expiry holds the sweep in place until the output register has room.
    assign tick_paused  = in_tick && any_hit && r_paused[hit_idx];
    assign tick_expire  = in_tick && any_hit && !r_paused[hit_idx] && alu_flag;
    assign tick_write   = in_tick && any_hit && !r_paused[hit_idx] &&
                          (!alu_flag || i_out_free);
    assign tick_advance = tick_paused || (tick_write && !alu_flag);

    assign start_en = in_exec && (r_op == ostb_pkg::OP_START) && !r_active[sidx];
    assign drop_en  = (tick_expire && i_out_free) ||
                      (in_exec && r_active[sidx] &&
                       ((r_op == ostb_pkg::OP_SET_DUR) || (r_op == ostb_pkg::OP_CANCEL)));
    assign drop_rank     = r_rank[rd_idx];
    assign clear_elapsed = in_exec && ((r_op == ostb_pkg::OP_SET_DUR) || start_en);

    assign ack_active = in_bank && r_active[sidx];

    assign o_in_ready = (r_state == ostb_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ostb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (ostb_pkg::t_op'(i_op) == ostb_pkg::OP_TICK) ?
                              ostb_pkg::ST_TICK : ostb_pkg::ST_EXEC;
                end
            end
            ostb_pkg::ST_EXEC: begin
                n_state = ostb_pkg::ST_ACK;
            end
            ostb_pkg::ST_ACK, ostb_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = ostb_pkg::ST_IDLE;
                end
            end
            ostb_pkg::ST_TICK: begin
                if (!any_hit) begin
                    n_state = ostb_pkg::ST_DONE;
                end
            end
            default: begin
                n_state = ostb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_emit_valid = 1'b0;
        o_emit       = '0;
        case (r_state)
            ostb_pkg::ST_ACK: begin
                o_emit_valid           = i_out_free;
                o_emit.which_slot      = r_slot;
                o_emit.remaining_units = (ack_active && !alu_flag) ? alu_res : '0;
                o_emit.is_active       = ack_active;
                o_emit.is_paused       = ack_active && r_paused[sidx];
                o_emit.last            = 1'b1;
            end
            ostb_pkg::ST_TICK: begin
                o_emit_valid      = tick_expire && i_out_free;
                o_emit.kind       = 1'b1;
                o_emit.which_slot = ostb_pkg::SLOT_W'(hit_idx);
            end
            ostb_pkg::ST_DONE: begin
                o_emit_valid = i_out_free;
                o_emit.last  = 1'b1;
            end
            default: begin
                o_emit_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ostb_pkg::ST_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ostb_pkg::ST_IDLE) begin
                r_ptr <= '0;
            end else if (tick_advance) begin
                r_ptr <= r_ptr + ostb_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op     <= ostb_pkg::t_op'(i_op);
            r_slot   <= i_slot;
            r_dur_in <= i_duration;
            r_delta  <= i_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_write) begin
            r_elapsed[hit_idx] <= alu_res;
        end else if (clear_elapsed) begin
            r_elapsed[sidx] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_paused <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i]     <= '0;
                r_duration[i] <= '0;
            end
        end else begin
            for (int i = 0; i < N; i++) begin
                if (start_en && r_active[i]) begin
                    r_rank[i] <= r_rank[i] + ostb_pkg::RANK_W'(1);
                end
                if (drop_en && r_active[i] && (ostb_pkg::SLOT_IDX_W'(i) != rd_idx) &&
                    (r_rank[i] > drop_rank)) begin
                    r_rank[i] <= r_rank[i] - ostb_pkg::RANK_W'(1);
                end
            end
            if (drop_en) begin
                r_active[rd_idx] <= 1'b0;
                r_rank[rd_idx]   <= '0;
            end
            if (in_exec) begin
                case (r_op)
                    ostb_pkg::OP_SET_DUR: begin
                        r_paused[sidx]   <= 1'b0;
                        r_duration[sidx] <= r_dur_in;
                    end
                    ostb_pkg::OP_START: begin
                        if (start_en) begin
                            r_active[sidx] <= 1'b1;
                            r_paused[sidx] <= 1'b0;
                            r_rank[sidx]   <= '0;
                        end
                    end
                    ostb_pkg::OP_PAUSE: begin
                        if (r_active[sidx]) begin
                            r_paused[sidx] <= 1'b1;
                        end
                    end
                    ostb_pkg::OP_RESUME: begin
                        if (r_active[sidx]) begin
                            r_paused[sidx] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign emit_blocked = o_emit_valid && !i_out_free;
    assign done_emit    = (r_state == ostb_pkg::ST_DONE) && o_emit_valid;

    `ASSERT_NEVER(a_emit_needs_room, i_clk, i_rst_n, emit_blocked, "item emitted without room")
    `ASSERT_AT(a_tick_closes, i_clk, i_rst_n, done_emit |=> o_in_ready, "tick did not close")
    `ASSERT_AT(a_rank_unique, i_clk, i_rst_n, in_tick |-> $onehot0(hit), "slots share a rank")

endmodule

[rtl/core/one_shot_timer_bank.sv]
// Bank of one-shot timer slots driven by one operation per input item. A tick walks the
// active slots in start order, newest first, one slot per cycle unless an expiry is held,
// through a single shared 32-bit saturating add and compare unit; it gives one expiry item
// for each slot that ran out and ends with an empty item marked last. Every other
// operation passes through accept, update and acknowledge states and gives one
// acknowledge item with the slot's status. The input is not ready while an item is being
// worked on, and the sweep holds whenever an expiry finds the output register still full.
module one_shot_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] slot, [34:3] duration_units, [50:35] delta_units, [55:51] zero
    input  logic [55:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] which_slot, [34:3] remaining_units, [35] is_active, [36] is_paused, [39:37] zero
    output logic [39:0] m_axis_tdata,
    // [0] kind
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    ostb_pkg::t_result r_out;
    logic              r_out_valid;
    logic              out_free;
    logic              emit_valid;
    ostb_pkg::t_result emit;

    assign out_free = !r_out_valid || m_axis_tready;

    ostb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_slot       (s_axis_tdata[2:0]),
        .i_duration   (s_axis_tdata[34:3]),
        .i_delta      (s_axis_tdata[50:35]),
        .i_out_free   (out_free),
        .o_emit_valid (emit_valid),
        .o_emit       (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid) begin
            r_out <= emit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.is_paused, r_out.is_active,
                            r_out.remaining_units, r_out.which_slot};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule
